// ----- rtl/core/kqd_pkg.sv -----
// ----------------------------------------------------------------------------
// kqd_pkg
// Shared types and constants for the quadrature knob dual counter.
// ----------------------------------------------------------------------------
package kqd_pkg;

	// default counter width, handed to the top level parameter
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	// fixed field widths
	localparam int unsigned STEP_W   = 8;
	localparam int unsigned PIN_W    = 6;
	localparam int unsigned OUT_W    = 32;
	localparam int unsigned CFG_IDX_W = 1;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RST     = 8'd1;
	localparam logic [PIN_W-1:0]  MODE_PIN_RST = 6'd25;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_SIZE = 1'b0,
		REG_MODE_PIN  = 1'b1
	} reg_idx_t;

	// item operation codes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_BUTTON = 1'b1
	} op_t;

	// one input item
	typedef struct packed {
		op_t              operation;
		logic             phase_a;
		logic             phase_c;
		logic [PIN_W-1:0] button_pin;
	} item_t;

endpackage

// ----- rtl/core/kqd_in_reg.sv -----
// ----------------------------------------------------------------------------
// kqd_in_reg
// Input register stage: holds one accepted item until the update stage takes it.
// ----------------------------------------------------------------------------
module kqd_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  kqd_pkg::item_t in_item,
	output logic          in_stall,
	input  logic          advance,
	output logic          valid_s1,
	output kqd_pkg::item_t item_s1
);

	logic load;

	// stage frees itself when its item moves on
	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/core/kqd_engine.sv -----
// ----------------------------------------------------------------------------
// kqd_engine
// Decoder state and update logic; the state registers double as result data.
// ----------------------------------------------------------------------------
module kqd_engine #(
	parameter int unsigned COUNT_WIDTH = kqd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  kqd_pkg::item_t              item_s1,
	input  logic [kqd_pkg::STEP_W-1:0]  step_size,
	input  logic [kqd_pkg::PIN_W-1:0]   mode_pin,
	output logic [COUNT_WIDTH-1:0]      cnt_main_q,
	output logic [COUNT_WIDTH-1:0]      cnt_alt_q,
	output logic                        sel_alt_q,
	output logic                        changed_q
);

	logic                   prev_a_q;
	logic                   prev_c_q;
	logic                   primed_q;
	logic                   do_add;
	logic                   do_sub;
	logic                   do_toggle;
	logic [COUNT_WIDTH-1:0] amount;
	logic [COUNT_WIDTH-1:0] base;
	logic [COUNT_WIDTH-1:0] result;

	always_comb begin
		do_add    = 1'b0;
		do_sub    = 1'b0;
		do_toggle = 1'b0;
		amount    = COUNT_WIDTH'(step_size);
		unique case (item_s1.operation)
			kqd_pkg::OP_SAMPLE: begin
				// a change wins over c change
				priority if (!primed_q) begin
				end else if (prev_a_q != item_s1.phase_a) begin
					do_add = prev_a_q & item_s1.phase_c;
				end else if (prev_c_q != item_s1.phase_c) begin
					do_sub = prev_c_q & item_s1.phase_a;
				end else begin
					// levels unchanged
				end
			end
			kqd_pkg::OP_BUTTON: begin
				if (item_s1.button_pin == mode_pin) begin
					do_toggle = 1'b1;
				end else begin
					do_add = 1'b1;
					amount = COUNT_WIDTH'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign base   = sel_alt_q ? cnt_alt_q : cnt_main_q;
	assign result = do_sub ? (base - amount) : (base + amount);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q   <= 1'b0;
			prev_c_q   <= 1'b0;
			primed_q   <= 1'b0;
			cnt_main_q <= '0;
			cnt_alt_q  <= '0;
			sel_alt_q  <= 1'b0;
			changed_q  <= 1'b0;
		end else if (fire) begin
			changed_q <= do_add | do_sub;
			if (item_s1.operation == kqd_pkg::OP_SAMPLE) begin
				prev_a_q <= item_s1.phase_a;
				prev_c_q <= item_s1.phase_c;
				primed_q <= 1'b1;
			end
			if (do_toggle) begin
				sel_alt_q <= ~sel_alt_q;
			end
			if (do_add | do_sub) begin
				if (sel_alt_q) begin
					cnt_alt_q <= result;
				end else begin
					cnt_main_q <= result;
				end
			end
		end
	end

endmodule

// ----- rtl/core/quadrature_knob_dual_counter_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_knob_dual_counter_unit
// Rotary knob decoder driving two wrapping counters, one selected at a time.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with operation, phase_a, phase_c,
//   button_pin; a phase sample (operation 0) or a button event (operation 1)
//   transfers when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall with count_main, count_alt, mode,
//   changed; one result per input item, in order
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data,
//   index 0 = step_size, index 1 = mode_pin; cfg_ready is always high,
//   write only while the block is idle
//   path: an accepted item is registered in the input register, then the
//   update writes the state/result registers, which drive the output
//   throughput: one item per cycle while out_stall is low; the single counter
//   adder from input register to state/result register sets the cycle
//   stall: while out_stall holds a result, the input register keeps one
//   more item and then in_stall rises; nothing is lost
//   reset: counters, mode and phase history clear, step_size goes to 1,
//   mode_pin to 25; the first phase sample only loads the phase levels
// ----------------------------------------------------------------------------
module quadrature_knob_dual_counter_unit #(
	parameter int unsigned COUNT_WIDTH = kqd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic                          phase_a,
	input  logic                          phase_c,
	input  logic [kqd_pkg::PIN_W-1:0]     button_pin,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [kqd_pkg::OUT_W-1:0] count_main,
	output logic signed [kqd_pkg::OUT_W-1:0] count_alt,
	output logic                          mode,
	output logic                          changed,
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kqd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kqd_pkg::STEP_W-1:0]    cfg_data
);

	kqd_pkg::item_t              in_item;
	kqd_pkg::item_t              item_s1;
	logic                        valid_s1;
	logic                        fire;
	logic                        out_valid_q;
	logic [kqd_pkg::STEP_W-1:0]  step_size_q;
	logic [kqd_pkg::PIN_W-1:0]   mode_pin_q;
	logic [COUNT_WIDTH-1:0]      cnt_main;
	logic [COUNT_WIDTH-1:0]      cnt_alt;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= kqd_pkg::STEP_RST;
			mode_pin_q  <= kqd_pkg::MODE_PIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (kqd_pkg::reg_idx_t'(cfg_index))
				kqd_pkg::REG_STEP_SIZE: step_size_q <= cfg_data;
				kqd_pkg::REG_MODE_PIN:  mode_pin_q  <= cfg_data[kqd_pkg::PIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input payload packed for the input register
	assign in_item.operation  = kqd_pkg::op_t'(operation);
	assign in_item.phase_a    = phase_a;
	assign in_item.phase_c    = phase_c;
	assign in_item.button_pin = button_pin;

	// the held item moves on when the result slot is empty or being drained
	assign fire = valid_s1 & (~out_valid_q | ~out_stall);

	kqd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.in_stall (in_stall),
		.advance  (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// state registers only change on fire, so they hold steady under stall
	// and serve directly as the result data
	kqd_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item_s1    (item_s1),
		.step_size  (step_size_q),
		.mode_pin   (mode_pin_q),
		.cnt_main_q (cnt_main),
		.cnt_alt_q  (cnt_alt),
		.sel_alt_q  (mode),
		.changed_q  (changed)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// sign-extend or truncate counters to the output width
	assign count_main = kqd_pkg::OUT_W'($signed(cnt_main));
	assign count_alt  = kqd_pkg::OUT_W'($signed(cnt_alt));

endmodule

// ----- rtl/core/kqd_checker.sv -----
// ----------------------------------------------------------------------------
// kqd_checker
// Port-level checks for the quadrature knob dual counter, bound to the top.
// ----------------------------------------------------------------------------
module kqd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [kqd_pkg::OUT_W-1:0]  count_main,
	input logic signed [kqd_pkg::OUT_W-1:0]  count_alt,
	input logic                              mode,
	input logic                              changed
);

	// held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// input backs up only behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// a result without a change keeps both counters
	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 (out_valid && !changed) |->
		count_main == $past(count_main) && count_alt == $past(count_alt))
		else $error("counter moved without changed");

	// a counting item never toggles the mode
	a_mode_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 (out_valid && changed) |->
		mode == $past(mode))
		else $error("mode toggled on a counting item");

endmodule

bind quadrature_knob_dual_counter_unit kqd_checker u_kqd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.count_main (count_main),
	.count_alt  (count_alt),
	.mode       (mode),
	.changed    (changed)
);
